// ===== hw/rtl/dots_pkg.sv =====
// Shared constants and types for the deadline-ordered timer set.
`default_nettype none
package dots_pkg;

  localparam int SLOTS   = 16;
  localparam int MaxRes  = 16;
  localparam int SlotW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CntW    = $clog2(SLOTS + 1);
  localparam int NumW    = $clog2(MaxRes + 1);
  localparam int TimeW   = 64;
  localparam int PerW    = 32;
  localparam int EntryW  = TimeW + PerW;

  localparam logic [2:0] OP_START_ONCE = 3'd0;
  localparam logic [2:0] OP_START_PER  = 3'd1;
  localparam logic [2:0] OP_STOP       = 3'd2;
  localparam logic [2:0] OP_TICK       = 3'd3;
  localparam logic [2:0] OP_CLEAR      = 3'd4;

  localparam logic [1:0] KIND_ACK    = 2'd0;
  localparam logic [1:0] KIND_EXPIRE = 2'd1;
  localparam logic [1:0] KIND_IDLE   = 2'd2;

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_ERR = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DECIDE = 4'b0100,
    S_FLUSH  = 4'b1000
  } state_e;

endpackage
`default_nettype wire

// ===== hw/rtl/deadline_ordered_timer_set.sv =====
// Top level of the deadline-ordered timer set.
`default_nettype none
// Commands enter on start_i while busy_o is low. Start, stop, clear and
// unknown operations answer with one acknowledge on the next cycle; busy_o
// stays low, so a new command can follow at once. A tick scans all SLOTS
// entries of the deadline/period RAM with 64-bit compares, then retires the
// winner in the decide state, repeated once per expiry plus one final scan
// that finds none. When 16 expire, a flush state replaces the final scan.
// Each result shows for one cycle on result_valid_o and cannot be held off; the
// expiries of one tick come in deadline order, the last one marked by last_o.
module deadline_ordered_timer_set (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [2:0]  operation_i,
  input  wire logic [3:0]  slot_i,
  input  wire logic [31:0] interval_i,
  output logic             result_valid_o,
  output logic [1:0]       kind_o,
  output logic [3:0]       fired_slot_o,
  output logic             status_o,
  output logic             last_o
);

  localparam int SLOTS = dots_pkg::SLOTS;
  localparam int SlotW = dots_pkg::SlotW;
  localparam int CntW  = dots_pkg::CntW;
  localparam int NumW  = dots_pkg::NumW;
  localparam int TimeW = dots_pkg::TimeW;
  localparam int PerW  = dots_pkg::PerW;
  localparam int EntryW = dots_pkg::EntryW;

  dots_pkg::state_e state_q, state_d;

  logic [TimeW-1:0] now_q, now_d;
  logic [SLOTS-1:0] active_q, active_d;
  logic [SLOTS-1:0] periodic_q, periodic_d;
  logic [SLOTS-1:0] done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [NumW-1:0]  n_q, n_d;
  logic             best_v_q, best_v_d;
  logic [SlotW-1:0] best_idx_q, best_idx_d;
  logic [TimeW-1:0] best_dl_q, best_dl_d;
  logic [PerW-1:0]  best_pd_q, best_pd_d;
  logic             pend_v_q, pend_v_d;
  logic [SlotW-1:0] pend_idx_q, pend_idx_d;

  logic             rv_q, rv_d;
  logic [1:0]       kind_q, kind_d;
  logic [3:0]       fslot_q, fslot_d;
  logic             status_q, status_d;
  logic             last_q, last_d;

  logic              ram_we;
  logic [SlotW-1:0]  ram_waddr;
  logic [EntryW-1:0] ram_wdata;
  logic [SlotW-1:0]  ram_raddr;
  logic [EntryW-1:0] ram_rdata;

  logic              accept;
  logic              in_rng;
  logic [SlotW-1:0]  sidx;
  logic [SlotW-1:0]  pidx;
  logic [TimeW-1:0]  rd_dl;
  logic [PerW-1:0]   rd_pd;
  logic [PerW-1:0]   step;

  dots_ram #(
    .Width(EntryW),
    .Depth(SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign busy_o = (state_q != dots_pkg::S_IDLE);
  assign accept = start_i && !busy_o;
  assign in_rng = ({28'd0, slot_i} < 32'(SLOTS));
  assign sidx   = SlotW'(slot_i);
  assign pidx   = SlotW'(cnt_q - CntW'(1));
  assign rd_dl  = ram_rdata[EntryW-1:PerW];
  assign rd_pd  = ram_rdata[PerW-1:0];
  // a period of zero re-arms one tick later
  assign step   = (best_pd_q == '0) ? PerW'(1) : best_pd_q;

  always_comb begin
    state_d    = state_q;
    now_d      = now_q;
    active_d   = active_q;
    periodic_d = periodic_q;
    done_d     = done_q;
    cnt_d      = cnt_q;
    n_d        = n_q;
    best_v_d   = best_v_q;
    best_idx_d = best_idx_q;
    best_dl_d  = best_dl_q;
    best_pd_d  = best_pd_q;
    pend_v_d   = pend_v_q;
    pend_idx_d = pend_idx_q;
    rv_d       = 1'b0;
    kind_d     = kind_q;
    fslot_d    = fslot_q;
    status_d   = status_q;
    last_d     = last_q;
    ram_we     = 1'b0;
    ram_waddr  = sidx;
    ram_wdata  = {now_q + TimeW'(interval_i), interval_i};
    ram_raddr  = cnt_q[SlotW-1:0];

    unique case (state_q)
      dots_pkg::S_IDLE: begin
        if (accept) begin
          rv_d     = 1'b1;
          kind_d   = dots_pkg::KIND_ACK;
          fslot_d  = slot_i;
          status_d = dots_pkg::ST_OK;
          last_d   = 1'b1;
          unique case (operation_i) inside
            dots_pkg::OP_START_ONCE, dots_pkg::OP_START_PER: begin
              if (in_rng) begin
                ram_we         = 1'b1;
                active_d[sidx] = 1'b1;
                periodic_d[sidx] = (operation_i == dots_pkg::OP_START_PER);
              end else begin
                status_d = dots_pkg::ST_ERR;
              end
            end
            dots_pkg::OP_STOP: begin
              if (in_rng && active_q[sidx]) begin
                active_d[sidx] = 1'b0;
              end else begin
                status_d = dots_pkg::ST_ERR;
              end
            end
            dots_pkg::OP_TICK: begin
              rv_d     = 1'b0;
              now_d    = now_q + TimeW'(1);
              done_d   = '0;
              n_d      = '0;
              cnt_d    = '0;
              best_v_d = 1'b0;
              pend_v_d = 1'b0;
              state_d  = dots_pkg::S_SCAN;
            end
            dots_pkg::OP_CLEAR: begin
              active_d = '0;
              fslot_d  = 4'd0;
            end
            default: begin
            end
          endcase
        end
      end

      dots_pkg::S_SCAN: begin
        // read data is registered, so it belongs to the previous address (pidx)
        if (cnt_q != '0) begin
          if (active_q[pidx] && !done_q[pidx] && (rd_dl <= now_q) &&
              (!best_v_q || (rd_dl < best_dl_q))) begin
            best_v_d   = 1'b1;
            best_idx_d = pidx;
            best_dl_d  = rd_dl;
            best_pd_d  = rd_pd;
          end
        end
        if (cnt_q == CntW'(SLOTS)) begin
          state_d = dots_pkg::S_DECIDE;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end

      dots_pkg::S_DECIDE: begin
        if (best_v_q) begin
          done_d[best_idx_q] = 1'b1;
          if (periodic_q[best_idx_q]) begin
            ram_we    = 1'b1;
            ram_waddr = best_idx_q;
            ram_wdata = {best_dl_q + TimeW'(step), best_pd_q};
          end else begin
            active_d[best_idx_q] = 1'b0;
          end
          // the previous expiry is sent once a later one is known
          if (pend_v_q) begin
            rv_d     = 1'b1;
            kind_d   = dots_pkg::KIND_EXPIRE;
            fslot_d  = 4'(pend_idx_q);
            status_d = dots_pkg::ST_OK;
            last_d   = 1'b0;
          end
          pend_v_d   = 1'b1;
          pend_idx_d = best_idx_q;
          n_d        = n_q + NumW'(1);
          if (n_q == NumW'(dots_pkg::MaxRes - 1)) begin
            state_d = dots_pkg::S_FLUSH;
          end else begin
            cnt_d    = '0;
            best_v_d = 1'b0;
            state_d  = dots_pkg::S_SCAN;
          end
        end else begin
          rv_d     = 1'b1;
          status_d = dots_pkg::ST_OK;
          last_d   = 1'b1;
          if (pend_v_q) begin
            kind_d  = dots_pkg::KIND_EXPIRE;
            fslot_d = 4'(pend_idx_q);
          end else begin
            kind_d  = dots_pkg::KIND_IDLE;
            fslot_d = 4'd0;
          end
          pend_v_d = 1'b0;
          state_d  = dots_pkg::S_IDLE;
        end
      end

      dots_pkg::S_FLUSH: begin
        rv_d     = 1'b1;
        kind_d   = dots_pkg::KIND_EXPIRE;
        fslot_d  = 4'(pend_idx_q);
        status_d = dots_pkg::ST_OK;
        last_d   = 1'b1;
        pend_v_d = 1'b0;
        state_d  = dots_pkg::S_IDLE;
      end

      default: begin
        state_d = dots_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= dots_pkg::S_IDLE;
      now_q      <= '0;
      active_q   <= '0;
      periodic_q <= '0;
      done_q     <= '0;
      cnt_q      <= '0;
      n_q        <= '0;
      best_v_q   <= 1'b0;
      pend_v_q   <= 1'b0;
      rv_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      now_q      <= now_d;
      active_q   <= active_d;
      periodic_q <= periodic_d;
      done_q     <= done_d;
      cnt_q      <= cnt_d;
      n_q        <= n_d;
      best_v_q   <= best_v_d;
      pend_v_q   <= pend_v_d;
      rv_q       <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_idx_q <= best_idx_d;
    best_dl_q  <= best_dl_d;
    best_pd_q  <= best_pd_d;
    pend_idx_q <= pend_idx_d;
    kind_q     <= kind_d;
    fslot_q    <= fslot_d;
    status_q   <= status_d;
    last_q     <= last_d;
  end

  assign result_valid_o = rv_q;
  assign kind_o         = kind_q;
  assign fired_slot_o   = fslot_q;
  assign status_o       = status_q;
  assign last_o         = last_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

  a_cmd_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && operation_i != dots_pkg::OP_TICK)
      |=> (result_valid_o && last_o && kind_o == dots_pkg::KIND_ACK))
    else $error("command beat without a single acknowledge");

  a_idle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && kind_o == dots_pkg::KIND_IDLE) |-> last_o)
    else $error("idle tick result not marked last");

  a_fire_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= NumW'(dots_pkg::MaxRes))
    else $error("too many expiries in one tick");

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && operation_i == dots_pkg::OP_TICK)
      |=> (busy_o && !result_valid_o))
    else $error("tick did not start a scan");

endmodule
`default_nettype wire

// ===== hw/rtl/dots_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dots_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]  waddr_i,
  input  wire logic [Width-1:0]                              wdata_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]  raddr_i,
  output logic      [Width-1:0]                              rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== tb/sv/tb_deadline_ordered_timer_set.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for deadline_ordered_timer_set: directed table, then random commands.
module tb_deadline_ordered_timer_set;

  // operation codes the block does not define; it only acknowledges them
  localparam logic [2:0] OP_RSVD_LO  = 3'd5;
  localparam logic [2:0] OP_RSVD_MID = 3'd6;
  localparam logic [2:0] OP_RSVD_HI  = 3'd7;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int RANDOM_ITEMS = 500;
  localparam int QUIET_TAIL   = 100;
  localparam int DRAIN_CYCLES = 64;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] slot;
    logic       status;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  slot;
    logic [31:0] ival;
    logic        typed;
    beat_t       ack;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [2:0]  operation_i = '0;
  logic [3:0]  slot_i = '0;
  logic [31:0] interval_i = '0;
  logic        busy_o;
  logic        result_valid_o;
  logic [1:0]  kind_o;
  logic [3:0]  fired_slot_o;
  logic        status_o;
  logic        last_o;

  // timer state as the block should hold it
  logic [63:0]                tb_now;
  logic [63:0]                arm_deadline [dots_pkg::SLOTS];
  logic [31:0]                arm_period [dots_pkg::SLOTS];
  logic [dots_pkg::SLOTS-1:0] is_armed;
  logic [dots_pkg::SLOTS-1:0] is_periodic;

  beat_t step_q[$];
  beat_t pending_beats[$];
  row_t  plan[$];

  int mismatches = 0;
  int cycles = 0;
  int random_sent = 0;
  bit idling_on = 1'b1;

  deadline_ordered_timer_set u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .operation_i   (operation_i),
    .slot_i        (slot_i),
    .interval_i    (interval_i),
    .result_valid_o(result_valid_o),
    .kind_o        (kind_o),
    .fired_slot_o  (fired_slot_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Fills step_q with the result beats one command causes and updates the timer state.
  function automatic void timer_set_response(input logic [2:0] op, input logic [3:0] slot,
                                             input logic [31:0] ival);
    logic [dots_pkg::SLOTS-1:0] fired;
    beat_t tail;
    int best;
    int n;
    bit scanning;
    step_q.delete();
    case (op) inside
      dots_pkg::OP_START_ONCE, dots_pkg::OP_START_PER: begin
        if (int'(slot) < dots_pkg::SLOTS) begin
          arm_deadline[slot] = tb_now + {32'd0, ival};
          arm_period[slot] = ival;
          is_periodic[slot] = (op == dots_pkg::OP_START_PER);
          is_armed[slot] = 1'b1;
          step_q.push_back({dots_pkg::KIND_ACK, slot, dots_pkg::ST_OK, 1'b1});
        end else begin
          step_q.push_back({dots_pkg::KIND_ACK, slot, dots_pkg::ST_ERR, 1'b1});
        end
      end
      dots_pkg::OP_STOP: begin
        if (int'(slot) < dots_pkg::SLOTS && is_armed[slot]) begin
          is_armed[slot] = 1'b0;
          step_q.push_back({dots_pkg::KIND_ACK, slot, dots_pkg::ST_OK, 1'b1});
        end else begin
          step_q.push_back({dots_pkg::KIND_ACK, slot, dots_pkg::ST_ERR, 1'b1});
        end
      end
      dots_pkg::OP_TICK: begin
        tb_now = tb_now + 64'd1;
        fired = '0;
        n = 0;
        scanning = 1'b1;
        while (scanning && n < dots_pkg::MaxRes) begin
          best = -1;
          // earliest due deadline; strict compare keeps the lower index on a tie
          for (int i = 0; i < dots_pkg::SLOTS; i++) begin
            if (is_armed[i] && !fired[i] && arm_deadline[i] <= tb_now) begin
              if (best < 0 || arm_deadline[i] < arm_deadline[best]) best = i;
            end
          end
          if (best < 0) begin
            scanning = 1'b0;
          end else begin
            fired[best] = 1'b1;
            if (is_periodic[best]) begin
              arm_deadline[best] = arm_deadline[best] +
                ((arm_period[best] == 32'd0) ? 64'd1 : {32'd0, arm_period[best]});
            end else begin
              is_armed[best] = 1'b0;
            end
            step_q.push_back({dots_pkg::KIND_EXPIRE, 4'(best), dots_pkg::ST_OK, 1'b0});
            n++;
          end
        end
        if (n == 0) begin
          step_q.push_back({dots_pkg::KIND_IDLE, 4'd0, dots_pkg::ST_OK, 1'b1});
        end else begin
          tail = step_q.pop_back();
          tail.last = 1'b1;
          step_q.push_back(tail);
        end
      end
      dots_pkg::OP_CLEAR: begin
        is_armed = '0;
        step_q.push_back({dots_pkg::KIND_ACK, 4'd0, dots_pkg::ST_OK, 1'b1});
      end
      default: begin
        step_q.push_back({dots_pkg::KIND_ACK, slot, dots_pkg::ST_OK, 1'b1});
      end
    endcase
  endfunction

  task automatic pause(input int n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Drives one command, waits for the beat to be taken, then queues its results.
  task automatic run_item(input logic [2:0] op, input logic [3:0] slot, input logic [31:0] ival,
                          input logic typed, input beat_t ack);
    operation_i <= op;
    slot_i <= slot;
    interval_i <= ival;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    timer_set_response(op, slot, ival);
    if (typed) begin
      pending_beats.push_back(ack);
    end else begin
      foreach (step_q[i]) pending_beats.push_back(step_q[i]);
    end
    if (idling_on && $urandom_range(0, 4) == 0) pause($urandom_range(1, 14));
  endtask

  task automatic add_row(input logic [2:0] op, input logic [3:0] slot, input logic [31:0] ival,
                         input logic typed, input logic [1:0] kind, input logic [3:0] fslot,
                         input logic status);
    row_t r;
    r.op = op;
    r.slot = slot;
    r.ival = ival;
    r.typed = typed;
    r.ack = {kind, fslot, status, 1'b1};
    plan.push_back(r);
  endtask

  function automatic logic [31:0] rand_interval();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick <= 5) return $urandom_range(0, 6);
    if (pick <= 7) return $urandom_range(0, 40);
    if (pick == 8) return $urandom;
    return 32'd0;
  endfunction

  function automatic logic [2:0] rand_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return dots_pkg::OP_START_ONCE;
    if (r < 40) return dots_pkg::OP_START_PER;
    if (r < 55) return dots_pkg::OP_STOP;
    if (r < 88) return dots_pkg::OP_TICK;
    if (r < 92) return dots_pkg::OP_CLEAR;
    return 3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
  endfunction

  task automatic random_item(input logic [2:0] op, input logic [3:0] slot,
                             input logic [31:0] ival);
    run_item(op, slot, ival, 1'b0, '0);
    random_sent++;
    if (random_sent >= RANDOM_ITEMS - QUIET_TAIL) idling_on = 1'b0;
  endtask

  always @(posedge clk_i) begin : scoreboard
    beat_t want;
    if (rst_ni && result_valid_o === 1'b1) begin
      if (pending_beats.size() == 0) begin
        $error("unexpected beat: kind %0d fired_slot %0d status %0d last %0d",
               kind_o, fired_slot_o, status_o, last_o);
        mismatches++;
      end else begin
        want = pending_beats.pop_front();
        if (kind_o !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, kind_o);
          mismatches++;
        end
        if (fired_slot_o !== want.slot) begin
          $error("fired_slot: expected %0d, actual %0d", want.slot, fired_slot_o);
          mismatches++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status_o);
          mismatches++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, last_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int pick;
    int cnt;
    bit all_slots;
    tb_now = '0;
    is_armed = '0;
    is_periodic = '0;
    for (int i = 0; i < dots_pkg::SLOTS; i++) begin
      arm_deadline[i] = '0;
      arm_period[i] = '0;
    end

    //      op                       slot   interval       typed
    //      kind                     slot   status
    add_row(dots_pkg::OP_TICK,       4'd0,  32'd0,          1,
            dots_pkg::KIND_IDLE,     4'd0,  dots_pkg::ST_OK);
    add_row(dots_pkg::OP_STOP,       4'd3,  32'd0,          1,
            dots_pkg::KIND_ACK,      4'd3,  dots_pkg::ST_ERR);
    add_row(OP_RSVD_LO,              4'd7,  32'hFFFF_FFFF,  1,
            dots_pkg::KIND_ACK,      4'd7,  dots_pkg::ST_OK);
    add_row(OP_RSVD_MID,             4'd0,  32'd5,          1,
            dots_pkg::KIND_ACK,      4'd0,  dots_pkg::ST_OK);
    add_row(OP_RSVD_HI,              4'd15, 32'd0,          1,
            dots_pkg::KIND_ACK,      4'd15, dots_pkg::ST_OK);
    add_row(dots_pkg::OP_START_ONCE, 4'd0,  32'd0,          1,
            dots_pkg::KIND_ACK,      4'd0,  dots_pkg::ST_OK);
    add_row(dots_pkg::OP_START_PER,  4'd15, 32'd0,          1,
            dots_pkg::KIND_ACK,      4'd15, dots_pkg::ST_OK);
    add_row(dots_pkg::OP_START_ONCE, 4'd5,  32'hFFFF_FFFF,  1,
            dots_pkg::KIND_ACK,      4'd5,  dots_pkg::ST_OK);
    add_row(dots_pkg::OP_START_PER,  4'd9,  32'd2,          1,
            dots_pkg::KIND_ACK,      4'd9,  dots_pkg::ST_OK);
    add_row(dots_pkg::OP_START_ONCE, 4'd2,  32'd1,          1,
            dots_pkg::KIND_ACK,      4'd2,  dots_pkg::ST_OK);
    add_row(dots_pkg::OP_TICK,       4'd0,  32'd0,          0,
            dots_pkg::KIND_ACK,      4'd0,  dots_pkg::ST_OK);
    add_row(dots_pkg::OP_TICK,       4'd0,  32'd0,          0,
            dots_pkg::KIND_ACK,      4'd0,  dots_pkg::ST_OK);
    add_row(dots_pkg::OP_TICK,       4'd0,  32'd0,          0,
            dots_pkg::KIND_ACK,      4'd0,  dots_pkg::ST_OK);
    add_row(dots_pkg::OP_TICK,       4'd0,  32'd0,          0,
            dots_pkg::KIND_ACK,      4'd0,  dots_pkg::ST_OK);
    add_row(dots_pkg::OP_STOP,       4'd15, 32'd0,          1,
            dots_pkg::KIND_ACK,      4'd15, dots_pkg::ST_OK);
    add_row(dots_pkg::OP_STOP,       4'd15, 32'd0,          1,
            dots_pkg::KIND_ACK,      4'd15, dots_pkg::ST_ERR);
    add_row(dots_pkg::OP_STOP,       4'd5,  32'd0,          1,
            dots_pkg::KIND_ACK,      4'd5,  dots_pkg::ST_OK);
    add_row(dots_pkg::OP_START_PER,  4'd4,  32'h8000_0000,  1,
            dots_pkg::KIND_ACK,      4'd4,  dots_pkg::ST_OK);
    add_row(dots_pkg::OP_CLEAR,      4'd6,  32'd0,          1,
            dots_pkg::KIND_ACK,      4'd0,  dots_pkg::ST_OK);
    add_row(dots_pkg::OP_TICK,       4'd0,  32'd0,          1,
            dots_pkg::KIND_IDLE,     4'd0,  dots_pkg::ST_OK);
    add_row(dots_pkg::OP_STOP,       4'd9,  32'd0,          1,
            dots_pkg::KIND_ACK,      4'd9,  dots_pkg::ST_ERR);
    // equal deadlines: lower slot must fire first
    add_row(dots_pkg::OP_START_ONCE, 4'd1,  32'd1,          1,
            dots_pkg::KIND_ACK,      4'd1,  dots_pkg::ST_OK);
    add_row(dots_pkg::OP_START_PER,  4'd0,  32'd1,          1,
            dots_pkg::KIND_ACK,      4'd0,  dots_pkg::ST_OK);
    add_row(dots_pkg::OP_TICK,       4'd0,  32'd0,          0,
            dots_pkg::KIND_ACK,      4'd0,  dots_pkg::ST_OK);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) run_item(plan[i].op, plan[i].slot, plan[i].ival, plan[i].typed,
                               plan[i].ack);

    while (random_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        random_item(rand_op(), 4'($urandom_range(0, 15)), rand_interval());
      end else if (pick <= 8) begin
        // arm a batch with short delays, then tick through it
        all_slots = ($urandom_range(0, 2) == 0);
        cnt = all_slots ? dots_pkg::SLOTS : $urandom_range(3, dots_pkg::SLOTS);
        for (int i = 0; i < cnt; i++) begin
          random_item($urandom_range(0, 1) ? dots_pkg::OP_START_PER : dots_pkg::OP_START_ONCE,
                      all_slots ? 4'(i) : 4'($urandom_range(0, 15)),
                      32'($urandom_range(0, 3)));
        end
        cnt = $urandom_range(1, 6);
        for (int i = 0; i < cnt; i++) random_item(dots_pkg::OP_TICK, 4'($urandom), $urandom);
      end else begin
        cnt = $urandom_range(2, 5);
        for (int i = 0; i < cnt; i++) begin
          random_item(dots_pkg::OP_STOP, 4'($urandom_range(0, 15)), $urandom);
        end
        if ($urandom_range(0, 1)) random_item(dots_pkg::OP_CLEAR, 4'($urandom), $urandom);
        random_item(dots_pkg::OP_TICK, 4'($urandom), $urandom);
      end
    end

    start_i <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
